### src/swst_pkg.sv
// Shared constants and types for the sliding window statistics block.
// No dependencies; every other file except swst_ram imports this package.
`timescale 1ns / 1ps

package swst_pkg;

  localparam int WINDOW_MAX = 256;
  localparam int ADDR_W     = $clog2(WINDOW_MAX);
  localparam int LEN_W      = 9;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 25;
  localparam int SUMSQ_W    = 39;
  localparam int MEAN_W     = 24;
  localparam int VAR_W      = 39;
  localparam int SD_W       = 24;
  localparam int OUT_W      = 128;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_POS = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_NEG = 16'sh8000;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WINDOW_MAX);

  // Results of the arithmetic unit for one word.
  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic [SD_W-1:0]          stdev;
  } swst_res_t;

endpackage

### src/swst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module swst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/swst_math.sv
// Arithmetic unit: mean, sample variance and standard deviation from the sums.
// Uses swst_pkg; one shared restoring divider and a digit-serial square root.
`timescale 1ns / 1ps

module swst_math
  import swst_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum,
  input  logic [SUMSQ_W-1:0]      sumsq,
  input  logic [LEN_W-1:0]        n,
  output logic                    done,
  output swst_res_t               res
);

  localparam int DIV_W = 56;
  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_MUL  = 3'd1;
  localparam logic [2:0] M_SUB  = 3'd2;
  localparam logic [2:0] M_DIVM = 3'd3;
  localparam logic [2:0] M_DIVV = 3'd4;
  localparam logic [2:0] M_SQRT = 3'd5;
  localparam logic [2:0] M_DONE = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [LEN_W-1:0]        n_r;
  logic [SUMSQ_W-1:0]      sumsq_r;
  logic [23:0]             abs_r;
  logic                    neg_r;
  logic [47:0]             nsq_r, s2_r;
  logic [15:0]             den_r;
  logic [DIV_W-1:0]        dq_r;
  logic [15:0]             drem_r, dden_r;
  logic [5:0]              cnt_r;
  logic [47:0]             rad_r;
  logic [25:0]             srem_r;
  logic [SD_W-1:0]         sroot_r;
  swst_res_t               res_r;

  logic [16:0]             dt;
  logic                    dge;
  logic [26:0]             sr2, strial;
  logic                    sge;
  logic [DIV_W-1:0]        dq_step;
  logic [15:0]             drem_step;
  logic [47:0]             num;

  // One restoring division step, one square-root step and the variance numerator.
  always_comb begin
    dt        = {drem_r, dq_r[DIV_W-1]};
    dge       = dt >= {1'b0, dden_r};
    drem_step = dge ? 16'(dt - {1'b0, dden_r}) : dt[15:0];
    dq_step   = {dq_r[DIV_W-2:0], dge};
    sr2       = {srem_r[24:0], rad_r[47:46]};
    strial    = {1'b0, sroot_r, 2'b01};
    sge       = sr2 >= strial;
    num       = nsq_r - s2_r;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      M_IDLE:  if (start) state_nxt = M_MUL;
      M_MUL:   state_nxt = M_SUB;
      M_SUB:   state_nxt = M_DIVM;
      M_DIVM:  if (cnt_r == 6'(DIV_W - 1)) state_nxt = (n_r > 9'd1) ? M_DIVV : M_DONE;
      M_DIVV:  if (cnt_r == 6'(DIV_W - 1)) state_nxt = M_SQRT;
      M_SQRT:  if (cnt_r == 6'(SD_W - 1)) state_nxt = M_DONE;
      M_DONE:  if (start) state_nxt = M_MUL;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      n_r     <= n;
      sumsq_r <= sumsq;
      neg_r   <= sum[SUM_W-1];
      abs_r   <= sum[SUM_W-1] ? 24'(-sum) : sum[23:0];
    end
    case (state_r)
      M_MUL: begin
        nsq_r <= 48'(n_r * sumsq_r);
        s2_r  <= 48'(abs_r * abs_r);
        den_r <= 16'(n_r * (n_r - 9'd1));
      end
      M_SUB: begin
        dq_r   <= {24'd0, abs_r, 8'd0};
        drem_r <= '0;
        dden_r <= {7'd0, n_r};
        cnt_r  <= '0;
        res_r.variance <= '0;
        res_r.stdev    <= '0;
      end
      M_DIVM: begin
        dq_r   <= dq_step;
        drem_r <= drem_step;
        cnt_r  <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_W - 1)) begin
          res_r.mean <= neg_r ? -$signed(dq_step[MEAN_W-1:0]) : $signed(dq_step[MEAN_W-1:0]);
          dq_r   <= {num, 8'd0};
          drem_r <= '0;
          dden_r <= den_r;
          cnt_r  <= '0;
        end
      end
      M_DIVV: begin
        dq_r   <= dq_step;
        drem_r <= drem_step;
        cnt_r  <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_W - 1)) begin
          res_r.variance <= dq_step[VAR_W-1:0];
          rad_r  <= {1'b0, dq_step[VAR_W-1:0], 8'd0};
          srem_r <= '0;
          sroot_r <= '0;
          cnt_r  <= '0;
        end
      end
      M_SQRT: begin
        rad_r <= {rad_r[45:0], 2'b00};
        cnt_r <= cnt_r + 6'd1;
        if (sge) begin
          srem_r  <= 26'(sr2 - strial);
          sroot_r <= {sroot_r[SD_W-2:0], 1'b1};
        end else begin
          srem_r  <= sr2[25:0];
          sroot_r <= {sroot_r[SD_W-2:0], 1'b0};
        end
        if (cnt_r == 6'(SD_W - 1)) begin
          res_r.stdev <= {sroot_r[SD_W-2:0], sge};
        end
      end
      default: ;
    endcase
  end

  assign done = (state_r == M_DONE);
  assign res  = res_r;

endmodule

### src/sliding_window_statistics.sv
// Top level of the sliding window statistics block.
// Uses swst_pkg, swst_ram for the sample window and swst_math for the arithmetic.
`timescale 1ns / 1ps

// Each input word pushes one signed sample into a ring window of
// window_length samples (0 acts as 1, above 256 as 256) and gives one output
// word with fill count, mean, sample variance, standard deviation, minimum
// and maximum. The time from one accepted word to the next is set by the
// arithmetic unit (two 56-step divisions and a 24-step square root; only the
// mean division while the window holds a single sample). When the evicted
// sample was the current minimum or maximum, a scan of the window memory runs
// in parallel, one entry per cycle, and the next word waits until both the
// scan and the arithmetic are done. A new word is taken while the previous
// result still waits in the output register. Writing window_length empties
// the window.

module sliding_window_statistics
  import swst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [LEN_W-1:0]     cfg_wdata,   // window_length
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [SAMPLE_W-1:0]  in_tdata,    // sample
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // fill_count[8:0], window_mean[32:9], window_variance[71:33],
  // window_stdev[95:72], window_min[111:96], window_max[127:112]
  output logic [OUT_W-1:0]     out_tdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_RUN   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  logic [LEN_W-1:0]            len_r, cnt_r;
  logic [ADDR_W-1:0]           wp_r, slot_r;
  logic signed [SUM_W-1:0]     sum_r;
  logic [SUMSQ_W-1:0]          sumsq_r;
  logic signed [SAMPLE_W-1:0]  min_r, max_r, x_r, old_r;
  logic [31:0]                 xsq_r, oldsq_r;
  logic                        full_r, rmin_r, rmax_r;
  logic                        scan_on_r, rd_pend_r;
  logic [LEN_W-1:0]            scan_idx_r;
  logic signed [SAMPLE_W-1:0]  smin_r, smax_r;
  logic                        out_valid_r;
  logic [OUT_W-1:0]            out_data_r;

  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_raddr;
  logic [SAMPLE_W-1:0]         ram_rdata;
  logic signed [SAMPLE_W-1:0]  rd_s;
  logic                        accept, scan_issue, scan_done, math_done, out_free;
  logic [LEN_W-1:0]            len_eff;
  swst_res_t                   mres;

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign rd_s       = $signed(ram_rdata);
  assign scan_issue = (state_r == S_RUN) && scan_on_r && (scan_idx_r < len_r);
  assign scan_done  = !scan_on_r || ((scan_idx_r == len_r) && !rd_pend_r);
  assign out_free   = !out_valid_r || out_tready;
  assign ram_we     = (state_r == S_UPD);
  assign ram_raddr  = (state_r == S_READ) ? slot_r : scan_idx_r[ADDR_W-1:0];

  // Effective window length from a configuration write.
  always_comb begin
    if (cfg_wdata == '0) len_eff = 9'd1;
    else if (cfg_wdata > LEN_MAX) len_eff = LEN_MAX;
    else len_eff = cfg_wdata;
  end

  swst_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_MAX)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (x_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  swst_math u_math (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_START),
    .sum   (sum_r),
    .sumsq (sumsq_r),
    .n     (cnt_r),
    .done  (math_done),
    .res   (mres)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_READ;
      S_READ:  state_nxt = S_UPD;
      S_UPD:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_START;
      S_START: state_nxt = S_RUN;
      S_RUN:   if (scan_done && math_done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LEN_MAX;
      wp_r        <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      min_r       <= SAMPLE_POS;
      max_r       <= SAMPLE_NEG;
      out_valid_r <= 1'b0;
      scan_on_r   <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // The output register loads a new word or drains the accepted one.
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cfg_wen) begin
        len_r   <= len_eff;
        wp_r    <= '0;
        cnt_r   <= '0;
        sum_r   <= '0;
        sumsq_r <= '0;
        min_r   <= SAMPLE_POS;
        max_r   <= SAMPLE_NEG;
      end
      case (state_r)
        S_UPD: begin
          cnt_r <= full_r ? len_r : cnt_r + 9'd1;
          wp_r  <= ({1'b0, slot_r} + 9'd1 >= len_r) ? '0 : slot_r + 8'd1;
        end
        S_SUM: begin
          sum_r   <= sum_r + SUM_W'(x_r) - (full_r ? SUM_W'(old_r) : '0);
          sumsq_r <= sumsq_r + SUMSQ_W'(xsq_r) - (full_r ? SUMSQ_W'(oldsq_r) : '0);
          if (!rmin_r && x_r < min_r) min_r <= x_r;
          if (!rmax_r && x_r > max_r) max_r <= x_r;
        end
        S_START: begin
          scan_on_r <= rmin_r || rmax_r;
          rd_pend_r <= 1'b0;
        end
        S_RUN: begin
          rd_pend_r <= scan_issue;
          if (scan_done && math_done) begin
            scan_on_r <= 1'b0;
            if (rmin_r) min_r <= smin_r;
            if (rmax_r) max_r <= smax_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= $signed(in_tdata);
      xsq_r  <= 32'($signed(in_tdata) * $signed(in_tdata));
      slot_r <= ({1'b0, wp_r} >= len_r) ? '0 : wp_r;
      full_r <= cnt_r >= len_r;
    end
    if (state_r == S_UPD) begin
      old_r   <= rd_s;
      oldsq_r <= 32'(rd_s * rd_s);
      rmin_r  <= full_r && (rd_s == min_r);
      rmax_r  <= full_r && (rd_s == max_r);
    end
    if (state_r == S_START) begin
      scan_idx_r <= '0;
      smin_r     <= SAMPLE_POS;
      smax_r     <= SAMPLE_NEG;
    end
    if (scan_issue) scan_idx_r <= scan_idx_r + 9'd1;
    if (state_r == S_RUN && rd_pend_r) begin
      if (rd_s < smin_r) smin_r <= rd_s;
      if (rd_s > smax_r) smax_r <= rd_s;
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r <= {max_r, min_r, mres.stdev, mres.variance, mres.mean, cnt_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### src/swst_checker.sv
// Port-level checks for the sliding window statistics block, bound to the top.
// Uses swst_pkg for field widths.
`timescale 1ns / 1ps

module swst_checker
  import swst_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OUT_W-1:0]    out_tdata
);

  // A stalled result word must stay offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // A result never reports an empty window.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:0] != 9'd0)
    else $error("zero fill count");

  // Minimum never exceeds maximum.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[111:96]) <= $signed(out_tdata[127:112]))
    else $error("minimum above maximum");

  // With one sample, variance and deviation are zero and min equals max.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8:0] == 9'd1 |->
      out_tdata[95:33] == '0 && out_tdata[111:96] == out_tdata[127:112])
    else $error("single-sample statistics wrong");

endmodule

bind sliding_window_statistics swst_checker u_swst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
